[rtl/quoted_word_tokenizer_core_macros.svh]
// assertion macros shared by the tokenizer checker
// no dependencies
`ifndef QUOTED_WORD_TOKENIZER_CORE_MACROS_SVH
`define QUOTED_WORD_TOKENIZER_CORE_MACROS_SVH

// property checked on every clock edge outside reset
`define QWT_ASSERT_CLK(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
        else $error("tokenizer assertion failed");

// property checked on every clock edge, reset included
`define QWT_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("tokenizer reset assertion failed");

`endif

[rtl/qwt_pkg.sv]
// types, constants and helpers for the quoted word tokenizer
// no dependencies; used by qwt_step, qwt_out_stage, the top level and the bench
package qwt_pkg;

    localparam logic [7:0] QUOTE_CH  = 8'h22;
    localparam logic [7:0] BSLASH_CH = 8'h5C;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_QUOTED = 2'd1,
        MODE_PLAIN  = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        STAT_OK     = 2'd0,
        STAT_EMPTY  = 2'd1,
        STAT_BSLASH = 2'd2,
        STAT_QUOTE  = 2'd3
    } status_t;

    typedef struct packed {
        mode_t      scan_mode;
        logic       escape_pending;
        logic [2:0] words_seen;
    } state_t;

    typedef struct packed {
        logic [7:0] char_out;
        logic       char_valid;
        logic       word_end;
        logic [2:0] word_index;
        logic       line_done;
        status_t    line_status;
        logic [2:0] word_count;
    } result_t;

    localparam state_t STATE_RESET = '{
        scan_mode: MODE_IDLE, escape_pending: 1'b0, words_seen: 3'd0
    };

    function automatic logic is_blank(input logic [7:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

endpackage

[rtl/qwt_step.sv]
// next-state and result logic for one tokenizer request
// depends on qwt_pkg
module qwt_step #(
    parameter int MAX_WORDS = 5
) (
    input  qwt_pkg::state_t  cur,
    input  logic [7:0]       char_in,
    input  logic             line_end,
    output qwt_pkg::state_t  nxt,
    output qwt_pkg::result_t res
);

    localparam logic [2:0] MaxWordsC = 3'(MAX_WORDS);

    qwt_pkg::mode_t mode;
    logic           esc;
    logic           kept;
    logic [2:0]     cnt;

    always_comb begin
        nxt  = cur;
        res  = '0;
        cnt  = cur.words_seen;
        kept = cur.words_seen < MaxWordsC;
        // an unused mode code behaves as between words
        unique case (cur.scan_mode)
            qwt_pkg::MODE_QUOTED: mode = qwt_pkg::MODE_QUOTED;
            qwt_pkg::MODE_PLAIN:  mode = qwt_pkg::MODE_PLAIN;
            default:              mode = qwt_pkg::MODE_IDLE;
        endcase
        esc = (mode == qwt_pkg::MODE_IDLE) ? 1'b0 : cur.escape_pending;
        nxt.scan_mode      = mode;
        nxt.escape_pending = esc;

        if (line_end) begin
            res.line_done = 1'b1;
            if (esc) begin
                res.line_status = qwt_pkg::STAT_BSLASH;
            end else if (mode == qwt_pkg::MODE_QUOTED) begin
                res.line_status = qwt_pkg::STAT_QUOTE;
            end else begin
                // open plain word closes at line end
                if (mode == qwt_pkg::MODE_PLAIN && kept) begin
                    res.word_end   = 1'b1;
                    res.word_index = cur.words_seen;
                    cnt            = cur.words_seen + 3'd1;
                end
                res.line_status = (cnt == 3'd0) ? qwt_pkg::STAT_EMPTY
                                                : qwt_pkg::STAT_OK;
            end
            res.word_count = cnt;
            nxt            = qwt_pkg::STATE_RESET;
        end else if (esc) begin
            nxt.escape_pending = 1'b0;
            if (kept) begin
                res.char_out   = char_in;
                res.char_valid = 1'b1;
                res.word_index = cur.words_seen;
            end
        end else begin
            unique case (mode)
                qwt_pkg::MODE_QUOTED: begin
                    if (char_in == qwt_pkg::QUOTE_CH) begin
                        nxt.scan_mode = qwt_pkg::MODE_IDLE;
                        if (kept) begin
                            res.word_end   = 1'b1;
                            res.word_index = cur.words_seen;
                            nxt.words_seen = cur.words_seen + 3'd1;
                        end
                    end else if (char_in == qwt_pkg::BSLASH_CH) begin
                        nxt.escape_pending = 1'b1;
                    end else if (kept) begin
                        res.char_out   = char_in;
                        res.char_valid = 1'b1;
                        res.word_index = cur.words_seen;
                    end
                end
                qwt_pkg::MODE_PLAIN: begin
                    if (char_in == qwt_pkg::BSLASH_CH) begin
                        nxt.escape_pending = 1'b1;
                    end else if (qwt_pkg::is_blank(char_in)) begin
                        nxt.scan_mode = qwt_pkg::MODE_IDLE;
                        if (kept) begin
                            res.word_end   = 1'b1;
                            res.word_index = cur.words_seen;
                            nxt.words_seen = cur.words_seen + 3'd1;
                        end
                    end else if (kept) begin
                        res.char_out   = char_in;
                        res.char_valid = 1'b1;
                        res.word_index = cur.words_seen;
                    end
                end
                default: begin
                    if (char_in == qwt_pkg::QUOTE_CH) begin
                        nxt.scan_mode = qwt_pkg::MODE_QUOTED;
                    end else if (char_in == qwt_pkg::BSLASH_CH) begin
                        nxt.scan_mode      = qwt_pkg::MODE_PLAIN;
                        nxt.escape_pending = 1'b1;
                    end else if (!qwt_pkg::is_blank(char_in)) begin
                        nxt.scan_mode = qwt_pkg::MODE_PLAIN;
                        if (kept) begin
                            res.char_out   = char_in;
                            res.char_valid = 1'b1;
                            res.word_index = cur.words_seen;
                        end
                    end
                end
            endcase
        end
    end

endmodule

[rtl/qwt_out_stage.sv]
// result register holding one tokenizer result until the receiver takes it
// depends on qwt_pkg
module qwt_out_stage (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             load,
    input  qwt_pkg::result_t res_in,
    input  logic             m_ready,
    output logic             m_valid,
    output qwt_pkg::result_t res_out
);

    logic             valid_reg;
    logic             valid_next;
    qwt_pkg::result_t res_reg;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res_in;
        end
    end

    assign m_valid = valid_reg;
    assign res_out = res_reg;

endmodule

[rtl/quoted_word_tokenizer_core.sv]
// Quoted word tokenizer, top level.
// Input channel (s_): one request per byte of a line in s_char_in, or a
// request with s_line_end high that closes the line and carries no byte.
// Result channel (m_): exactly one result per request, in order. A result
// carries a kept word byte (m_char_valid) with its m_word_index, a word end
// (m_word_end), or on the line-end request m_line_done with m_line_status
// (ok, no words, backslash at end, unbalanced quote) and m_word_count.
// Whitespace splits words, double quotes group a word with its blanks,
// a backslash makes the next byte literal. Words past MAX_WORDS are dropped.
// A request goes through the input register, then the result register,
// before its result shows on m_valid. Throughput: one request per cycle
// while the receiver does not stall, set by the single state update
// between the two registers.
// When the receiver stalls, the result register holds and the input
// register takes one more request; s_ready then drops until m_ready returns.
// Reset (aresetn low, synchronous) empties both registers and returns the
// scanner to between words with no words counted.
// Depends on qwt_pkg, qwt_step and qwt_out_stage.
module quoted_word_tokenizer_core #(
    parameter int MAX_WORDS = 5
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_char_in,
    input  logic       s_line_end,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_char_out,
    output logic       m_char_valid,
    output logic       m_word_end,
    output logic [2:0] m_word_index,
    output logic       m_line_done,
    output logic [1:0] m_line_status,
    output logic [2:0] m_word_count
);

    logic             in_valid_reg;
    logic             in_valid_next;
    logic [7:0]       in_char_reg;
    logic             in_le_reg;
    qwt_pkg::state_t  state_reg;
    qwt_pkg::state_t  state_next;
    qwt_pkg::result_t step_res;
    qwt_pkg::result_t out_res;
    logic             advance;
    logic             s_fire;

    // input register moves on when the result register is free or draining
    assign advance = in_valid_reg && (!m_valid || m_ready);
    assign s_ready = !in_valid_reg || !m_valid || m_ready;
    assign s_fire  = s_valid && s_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_fire) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            state_reg    <= qwt_pkg::STATE_RESET;
        end else begin
            in_valid_reg <= in_valid_next;
            if (advance) begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_char_reg <= s_char_in;
            in_le_reg   <= s_line_end;
        end
    end

    qwt_step #(
        .MAX_WORDS (MAX_WORDS)
    ) u_step (
        .cur      (state_reg),
        .char_in  (in_char_reg),
        .line_end (in_le_reg),
        .nxt      (state_next),
        .res      (step_res)
    );

    qwt_out_stage u_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (advance),
        .res_in  (step_res),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .res_out (out_res)
    );

    assign m_char_out    = out_res.char_out;
    assign m_char_valid  = out_res.char_valid;
    assign m_word_end    = out_res.word_end;
    assign m_word_index  = out_res.word_index;
    assign m_line_done   = out_res.line_done;
    assign m_line_status = out_res.line_status;
    assign m_word_count  = out_res.word_count;

endmodule

[rtl/qwt_checker.sv]
// port-level assertions for the quoted word tokenizer, bound to the top level
// depends on quoted_word_tokenizer_core_macros.svh and the top level's ports
`include "quoted_word_tokenizer_core_macros.svh"

module qwt_checker #(
    parameter int MAX_WORDS = 5
) (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_char_out,
    input logic       m_char_valid,
    input logic       m_word_end,
    input logic [2:0] m_word_index,
    input logic       m_line_done,
    input logic [1:0] m_line_status,
    input logic [2:0] m_word_count
);

    localparam logic [2:0] MaxWordsC = 3'(MAX_WORDS);

    // a stalled result holds
    `QWT_ASSERT_CLK(a_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_char_out) && $stable(m_char_valid) && $stable(m_word_end) && $stable(m_word_index) && $stable(m_line_done) && $stable(m_line_status) && $stable(m_word_count))

    // line summary fields only on the line-end result, never with a byte
    `QWT_ASSERT_CLK(a_line, aclk, aresetn, m_valid && !m_line_done |-> m_line_status == 2'd0 && m_word_count == 3'd0)
    `QWT_ASSERT_CLK(a_done, aclk, aresetn, m_valid && m_line_done |-> !m_char_valid && m_word_count <= MaxWordsC && (m_line_status != 2'd1 || m_word_count == 3'd0))

    // kept words stay under the limit
    `QWT_ASSERT_CLK(a_index, aclk, aresetn, m_valid && (m_char_valid || m_word_end) |-> m_word_index < MaxWordsC)

    // reset empties the result register
    `QWT_ASSERT_ALWAYS(a_reset, aclk, !aresetn |=> !m_valid)

endmodule

bind quoted_word_tokenizer_core qwt_checker #(
    .MAX_WORDS (MAX_WORDS)
) u_qwt_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_char_out    (m_char_out),
    .m_char_valid  (m_char_valid),
    .m_word_end    (m_word_end),
    .m_word_index  (m_word_index),
    .m_line_done   (m_line_done),
    .m_line_status (m_line_status),
    .m_word_count  (m_word_count)
);

[bench/quoted_word_tokenizer_core_checker.sv]
`timescale 1ns / 100ps
// result checker for quoted_word_tokenizer_core: tracks the scanner state,
// predicts one result per request and compares it field by field; uses qwt_pkg
module quoted_word_tokenizer_core_checker
    import qwt_pkg::*;
#(
    parameter int MAX_WORDS = 5
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic [7:0] s_char_in,
    input  logic       s_line_end,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic [7:0] m_char_out,
    input  logic       m_char_valid,
    input  logic       m_word_end,
    input  logic [2:0] m_word_index,
    input  logic       m_line_done,
    input  logic [1:0] m_line_status,
    input  logic [2:0] m_word_count,
    output int         error_count,
    output int         pending_results
);

    localparam int PRINT_LIMIT = 40;

    mode_t      tok_mode;
    logic       tok_escape;
    logic [2:0] tok_words;
    result_t    expected_q[$];
    result_t    want;

    initial begin
        error_count     = 0;
        pending_results = 0;
    end

    task automatic report_error(input string msg);
        if (error_count < PRINT_LIMIT) begin
            $display("%0t: mismatch: %s", $realtime, msg);
        end
        error_count++;
    endtask

    task automatic compare_field(input string name, input logic [7:0] got_v,
                                 input logic [7:0] want_v);
        if (got_v !== want_v) begin
            report_error($sformatf("%s got %0h, expected %0h", name, got_v, want_v));
        end
    endtask

    // bytes of words past the limit are swallowed
    task automatic keep_byte(input logic [7:0] c, inout result_t r);
        if (tok_words < MAX_WORDS) begin
            r.char_out   = c;
            r.char_valid = 1'b1;
            r.word_index = tok_words;
        end
    endtask

    task automatic close_word(inout result_t r);
        if (tok_words < MAX_WORDS) begin
            r.word_end   = 1'b1;
            r.word_index = tok_words;
            tok_words    = tok_words + 3'd1;
        end
    endtask

    task automatic tokenize(input logic [7:0] c, input logic le, output result_t r);
        r = '0;
        if (tok_mode == MODE_IDLE) tok_escape = 1'b0;
        if (le) begin
            if (tok_escape) begin
                r.line_status = STAT_BSLASH;
            end else if (tok_mode == MODE_QUOTED) begin
                r.line_status = STAT_QUOTE;
            end else begin
                if (tok_mode == MODE_PLAIN) close_word(r);
                if (tok_words == 3'd0) r.line_status = STAT_EMPTY;
                else r.line_status = STAT_OK;
            end
            r.line_done  = 1'b1;
            r.word_count = tok_words;
            tok_mode     = MODE_IDLE;
            tok_escape   = 1'b0;
            tok_words    = 3'd0;
        end else if (tok_escape) begin
            tok_escape = 1'b0;
            keep_byte(c, r);
        end else begin
            case (tok_mode)
                MODE_QUOTED: begin
                    if (c == QUOTE_CH) begin
                        close_word(r);
                        tok_mode = MODE_IDLE;
                    end else if (c == BSLASH_CH) begin
                        tok_escape = 1'b1;
                    end else begin
                        keep_byte(c, r);
                    end
                end
                MODE_PLAIN: begin
                    if (c == BSLASH_CH) begin
                        tok_escape = 1'b1;
                    end else if (c inside {8'h20, [8'h09:8'h0D]}) begin
                        close_word(r);
                        tok_mode = MODE_IDLE;
                    end else begin
                        keep_byte(c, r);
                    end
                end
                default: begin
                    if (c == QUOTE_CH) begin
                        tok_mode = MODE_QUOTED;
                    end else if (c == BSLASH_CH) begin
                        tok_mode   = MODE_PLAIN;
                        tok_escape = 1'b1;
                    end else if (!(c inside {8'h20, [8'h09:8'h0D]})) begin
                        tok_mode = MODE_PLAIN;
                        keep_byte(c, r);
                    end
                end
            endcase
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            tok_mode   = MODE_IDLE;
            tok_escape = 1'b0;
            tok_words  = 3'd0;
            expected_q.delete();
        end else begin
            // push first so a same-edge result still pops the older request
            if (s_valid && s_ready) begin
                tokenize(s_char_in, s_line_end, want);
                expected_q.push_back(want);
            end
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    report_error("result with no request pending");
                end else begin
                    want = expected_q.pop_front();
                    compare_field("char_out", m_char_out, want.char_out);
                    compare_field("char_valid", m_char_valid, want.char_valid);
                    compare_field("word_end", m_word_end, want.word_end);
                    compare_field("word_index", m_word_index, want.word_index);
                    compare_field("line_done", m_line_done, want.line_done);
                    compare_field("line_status", m_line_status, want.line_status);
                    compare_field("word_count", m_word_count, want.word_count);
                end
            end
        end
        pending_results = expected_q.size();
    end

endmodule

[bench/quoted_word_tokenizer_core_tb.sv]
`timescale 1ns / 100ps
// testbench top for quoted_word_tokenizer_core: clock, reset, line and stall
// generation and the verdict; uses qwt_pkg and quoted_word_tokenizer_core_checker
module quoted_word_tokenizer_core_tb;
    import qwt_pkg::*;

    localparam int         MAX_WORDS     = 5;
    localparam int         REQUEST_COUNT = 1950;
    localparam logic [7:0] SPACE_CH      = 8'h20;
    localparam logic [7:0] TAB_CH        = 8'h09;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_char_in;
    logic       s_line_end;
    logic       m_valid;
    logic       m_ready;
    logic [7:0] m_char_out;
    logic       m_char_valid;
    logic       m_word_end;
    logic [2:0] m_word_index;
    logic       m_line_done;
    logic [1:0] m_line_status;
    logic [2:0] m_word_count;
    int         error_count;
    int         pending_results;

    int         sent_count;
    int         burst_left;
    logic [7:0] line_q[$];

    quoted_word_tokenizer_core #(.MAX_WORDS(MAX_WORDS)) dut (.*);

    quoted_word_tokenizer_core_checker #(.MAX_WORDS(MAX_WORDS)) checker_i (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #10_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // receiver: spans of always ready, coin flips, sparse ready, mostly ready and full stalls
    initial begin : ready_pattern
        int mode;
        int span;
        m_ready = 1'b0;
        forever begin
            mode = $urandom_range(0, 4);
            span = (mode == 4) ? $urandom_range(5, 40) : $urandom_range(10, 120);
            repeat (span) begin
                @(negedge aclk);
                case (mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= 1'($urandom_range(0, 1));
                    2: m_ready <= ($urandom_range(0, 3) == 0);
                    3: m_ready <= ($urandom_range(0, 15) != 0);
                    default: m_ready <= 1'b0;
                endcase
            end
        end
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_request(input logic [7:0] c, input logic le);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            case ($urandom_range(0, 3))
                0: gap = 0;
                1: gap = $urandom_range(1, 2);
                2: gap = $urandom_range(1, 6);
                default: gap = $urandom_range(8, 20);
            endcase
        end
        burst_left--;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid    <= 1'b1;
        s_char_in  <= c;
        s_line_end <= le;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        sent_count++;
    endtask

    task automatic send_line();
        foreach (line_q[i]) send_request(line_q[i], 1'b0);
        send_request(8'($urandom_range(0, 255)), 1'b1);
        line_q.delete();
    endtask

    task automatic wait_for_results();
        s_valid <= 1'b0;
        do @(negedge aclk); while (pending_results != 0);
    endtask

    function automatic logic [7:0] pick_blank();
        int k;
        k = $urandom_range(0, 5);
        if (k == 5) return SPACE_CH;
        return TAB_CH + 8'(k);
    endfunction

    function automatic logic [7:0] pick_content();
        case ($urandom_range(0, 9))
            0, 1: return 8'($urandom_range(0, 255));
            2: return QUOTE_CH;
            3: return BSLASH_CH;
            4: return pick_blank();
            default: return 8'($urandom_range(8'h21, 8'h7E));
        endcase
    endfunction

    task automatic add_plain_word(input int len);
        logic [7:0] c;
        for (int i = 0; i < len; i++) begin
            c = pick_content();
            if (c == BSLASH_CH) begin
                line_q.push_back(c);
                c = pick_content();
            end else if (c inside {SPACE_CH, [8'h09:8'h0D]}) begin
                c = c + 8'h40;
            end else if (i == 0 && c == QUOTE_CH) begin
                // a leading quote would open a quoted word instead
                c = 8'h27;
            end
            line_q.push_back(c);
        end
    endtask

    task automatic add_quoted_word(input int len);
        logic [7:0] c;
        line_q.push_back(QUOTE_CH);
        repeat (len) begin
            c = pick_content();
            if (c == QUOTE_CH || c == BSLASH_CH) begin
                line_q.push_back(BSLASH_CH);
                c = pick_content();
            end
            line_q.push_back(c);
        end
        line_q.push_back(QUOTE_CH);
    endtask

    task automatic add_blanks();
        repeat ($urandom_range(1, 3)) line_q.push_back(pick_blank());
    endtask

    // mostly well-formed lines, some ending on an escape or an open quote,
    // some plain noise
    task automatic build_line();
        int  kind;
        int  n_words;
        logic quoted;
        kind    = $urandom_range(0, 19);
        n_words = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 8) : $urandom_range(0, 4);
        if (kind < 2) begin
            repeat ($urandom_range(0, 16)) line_q.push_back(pick_content());
        end else begin
            if ($urandom_range(0, 2) == 0) add_blanks();
            for (int w = 0; w < n_words; w++) begin
                quoted = ($urandom_range(0, 2) == 0);
                if (quoted) add_quoted_word($urandom_range(0, 6));
                else add_plain_word($urandom_range(1, 6));
                if (w < n_words - 1) begin
                    if (!quoted || $urandom_range(0, 1)) add_blanks();
                end else if ($urandom_range(0, 2) == 0) begin
                    add_blanks();
                end
            end
            if (kind == 2) begin
                line_q.push_back(BSLASH_CH);
            end else if (kind == 3) begin
                add_blanks();
                line_q.push_back(QUOTE_CH);
                repeat ($urandom_range(0, 4)) line_q.push_back(8'($urandom_range(8'h61, 8'h7A)));
            end
        end
    endtask

    initial begin
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_char_in  = 8'h00;
        s_line_end = 1'b0;
        sent_count = 0;
        burst_left = 0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // empty line
        send_line();
        // empty quoted word, byte right after a closing quote, quote inside a
        // plain word, escaped blank opening a word, zero and all-ones bytes
        line_q = '{QUOTE_CH, QUOTE_CH, 8'h61, QUOTE_CH, TAB_CH, BSLASH_CH, SPACE_CH,
                   8'h00, 8'hFF, SPACE_CH};
        send_line();
        // five empty words, then a dropped word left open by a lone quote
        repeat (11) line_q.push_back(QUOTE_CH);
        send_line();
        // backslash at end of line
        line_q = '{8'h7A, BSLASH_CH};
        send_line();
        wait_for_results();

        while (sent_count < REQUEST_COUNT) begin
            build_line();
            send_line();
            if ($urandom_range(0, 40) == 0) wait_for_results();
        end

        wait_for_results();
        repeat (10) @(posedge aclk);
        if (error_count == 0 && pending_results == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

[quoted_word_tokenizer_core.f]
+incdir+rtl
rtl/qwt_pkg.sv
rtl/qwt_step.sv
rtl/qwt_out_stage.sv
rtl/quoted_word_tokenizer_core.sv
rtl/qwt_checker.sv
bench/quoted_word_tokenizer_core_checker.sv
bench/quoted_word_tokenizer_core_tb.sv
